[rtl/glp_pkg.sv]
// Shared types, codes and the number-field step function for the line parser.
// No dependencies; used by glp_num_lane and genomic_interval_line_parser_core.
package glp_pkg;

	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_HASH  = 8'd35;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_DEL   = 8'd127;

	localparam logic [1:0] CLS_EMPTY   = 2'd0;
	localparam logic [1:0] CLS_COMMENT = 2'd1;
	localparam logic [1:0] CLS_OK      = 2'd2;
	localparam logic [1:0] CLS_ERROR   = 2'd3;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_FEW      = 2'd1;
	localparam logic [1:0] ERR_NEGATIVE = 2'd2;
	localparam logic [1:0] ERR_BAD_NUM  = 2'd3;

	localparam logic [1:0] STR_UNKNOWN = 2'd0;
	localparam logic [1:0] STR_PLUS    = 2'd1;
	localparam logic [1:0] STR_MINUS   = 2'd2;

	typedef enum logic [1:0] {
		PH_LEAD,
		PH_COMMENT,
		PH_DATA
	} phase_t;

	typedef enum logic [2:0] {
		NS_LEAD,
		NS_SIGN,
		NS_DIGIT,
		NS_TRAIL,
		NS_BAD,
		NS_NEG
	} num_state_t;

	typedef struct packed {
		num_state_t  st;
		logic [31:0] acc;
	} num_t;

	function automatic logic is_blank(input logic [7:0] b);
		return (b == CH_SPACE) || (b >= 8'd9 && b <= 8'd13);
	endfunction

	function automatic num_t num_step(input num_t cur, input logic [7:0] b);
		num_t        nx;
		logic        dig;
		logic [3:0]  d;
		logic [35:0] prod;
		nx   = cur;
		dig  = (b >= 8'd48) && (b <= 8'd57);
		d    = 4'(b - 8'd48);
		prod = ({4'd0, cur.acc} << 3) + ({4'd0, cur.acc} << 1) + 36'(d);
		case (cur.st)
			NS_LEAD: begin
				if (!is_blank(b)) begin
					if (b == CH_MINUS) nx.st = NS_NEG;
					else if (b == CH_PLUS) nx.st = NS_SIGN;
					else if (dig) begin
						nx.st  = NS_DIGIT;
						nx.acc = 32'(d);
					end else nx.st = NS_BAD;
				end
			end
			NS_SIGN: begin
				if (dig) begin
					nx.st  = NS_DIGIT;
					nx.acc = 32'(d);
				end else nx.st = NS_BAD;
			end
			NS_DIGIT: begin
				if (dig) begin
					if (prod[35:32] != 4'd0) nx.st = NS_BAD;
					else nx.acc = prod[31:0];
				end else if (is_blank(b)) nx.st = NS_TRAIL;
				else nx.st = NS_BAD;
			end
			NS_TRAIL: begin
				if (!is_blank(b)) nx.st = NS_BAD;
			end
			default: ;
		endcase
		return nx;
	endfunction

	function automatic logic [1:0] num_error(input num_state_t st);
		if (st == NS_DIGIT || st == NS_TRAIL) return ERR_NONE;
		return (st == NS_NEG) ? ERR_NEGATIVE : ERR_BAD_NUM;
	endfunction

endpackage

[rtl/glp_num_lane.sv]
// One numeric field scanner: working and committed state of a decimal field.
// Depends on glp_pkg (num_t, num_step).
module glp_num_lane (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic          hit,
	input  logic          commit,
	input  logic          clear,
	input  logic [7:0]    data,
	output glp_pkg::num_t num
);
	import glp_pkg::*;

	num_t work_q, comm_q, nx;

	always_comb begin
		nx = work_q;
		if (hit) nx = num_step(work_q, data);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_q <= '{st: NS_LEAD, acc: '0};
			comm_q <= '{st: NS_LEAD, acc: '0};
		end else if (clear) begin
			work_q <= '{st: NS_LEAD, acc: '0};
			comm_q <= '{st: NS_LEAD, acc: '0};
		end else if (step) begin
			work_q <= nx;
			if (commit) comm_q <= nx;
		end
	end

	assign num = comm_q;
endmodule

[rtl/genomic_interval_line_parser_core.sv]
// Streaming BED/GFF line parser, one line byte per item.
// A line-end byte passes the input register, then its result is held in the output register.
// Accepts one byte per cycle except for the stall below, as the state is updated per byte.
// A result waiting in the output register stalls input only at the next line end.
// Reset (arst_n low) clears all parse state, the format register and both valids.
// Depends on glp_pkg and glp_num_lane.
module genomic_interval_line_parser_core #(
	parameter int LINE_LENGTH_MAX = 65535,
	parameter int FIELD_COUNT_MAX = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        record_format,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  line_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  line_class,
	output logic [1:0]  error_kind,
	output logic [7:0]  field_count,
	output logic [31:0] start_coord,
	output logic [31:0] end_coord,
	output logic [1:0]  strand_code,
	output logic [15:0] chrom_offset,
	output logic [15:0] chrom_length,
	output logic [15:0] name_offset,
	output logic [15:0] name_length,
	output logic [15:0] comment_offset,
	output logic [15:0] line_length
);
	import glp_pkg::*;

	localparam int PW = $clog2(LINE_LENGTH_MAX + 1);
	localparam int FW = $clog2(FIELD_COUNT_MAX + 1);

	typedef struct packed {
		logic [PW-1:0] pos;
		logic [FW-1:0] fidx;
		phase_t        phase;
		logic [PW-1:0] cpos;
		logic          cfound;
		logic [PW-1:0] off1;
		logic [PW-1:0] off2;
		logic [PW-1:0] off3;
		logic [PW-1:0] off4;
		logic [1:0]    strand5;
		logic [1:0]    strand6;
		logic          taken5;
		logic          taken6;
	} pstate_t;

	logic          fmt_q;
	logic [7:0]    byte_s1;
	logic          vld_s1;
	logic          adv, is_nl, step, commit;
	pstate_t       work_q, comm_q, nx;
	logic [PW-1:0] pos_inc;
	num_t          num [4];

	assign cfg_ready = 1'b1;
	assign is_nl     = (byte_s1 == CH_NL);
	assign adv       = vld_s1 && (!is_nl || !out_valid || out_ready);
	assign in_ready  = !vld_s1 || adv;
	assign step      = adv && !is_nl;
	assign commit    = (byte_s1 >= CH_SPACE) && (byte_s1 != CH_DEL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fmt_q <= 1'b0;
		else if (cfg_valid) fmt_q <= record_format;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (in_ready) vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) byte_s1 <= line_byte;
	end

	assign pos_inc = (work_q.pos == PW'(LINE_LENGTH_MAX)) ? work_q.pos : work_q.pos + 1'b1;

	always_comb begin
		nx = work_q;
		if (byte_s1 == CH_TAB) begin
			if (work_q.fidx != FW'(FIELD_COUNT_MAX)) nx.fidx = work_q.fidx + 1'b1;
			if (nx.fidx == FW'(1)) nx.off1 = pos_inc;
			if (nx.fidx == FW'(2)) nx.off2 = pos_inc;
			if (nx.fidx == FW'(3)) nx.off3 = pos_inc;
			if (nx.fidx == FW'(4)) nx.off4 = pos_inc;
		end else begin
			if (work_q.fidx == FW'(5) && !work_q.taken5) begin
				nx.taken5  = 1'b1;
				nx.strand5 = (byte_s1 == CH_PLUS) ? STR_PLUS :
					((byte_s1 == CH_MINUS) ? STR_MINUS : STR_UNKNOWN);
			end
			if (work_q.fidx == FW'(6) && !work_q.taken6) begin
				nx.taken6  = 1'b1;
				nx.strand6 = (byte_s1 == CH_PLUS) ? STR_PLUS :
					((byte_s1 == CH_MINUS) ? STR_MINUS : STR_UNKNOWN);
			end
		end
		if (work_q.phase == PH_LEAD) begin
			if (byte_s1 != CH_SPACE && byte_s1 != CH_TAB) begin
				if (byte_s1 == CH_HASH) begin
					nx.phase = PH_COMMENT;
					nx.cpos  = pos_inc;
				end else nx.phase = PH_DATA;
			end
		end else if (work_q.phase == PH_COMMENT && !work_q.cfound) begin
			if (byte_s1 != CH_SPACE && byte_s1 != CH_TAB) begin
				nx.cfound = 1'b1;
				nx.cpos   = work_q.pos;
			end
		end
		nx.pos = pos_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_q <= '{phase: PH_LEAD, default: '0};
			comm_q <= '{phase: PH_LEAD, default: '0};
		end else if (adv && is_nl) begin
			work_q <= '{phase: PH_LEAD, default: '0};
			comm_q <= '{phase: PH_LEAD, default: '0};
		end else if (step) begin
			work_q <= nx;
			if (commit) comm_q <= nx;
		end
	end

	for (genvar k = 0; k < 4; k++) begin : g_lane
		glp_num_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (step),
			.hit    (byte_s1 != CH_TAB && work_q.fidx == FW'(k + 1)),
			.commit (commit),
			.clear  (adv && is_nl),
			.data   (byte_s1),
			.num    (num[k])
		);
	end

	function automatic logic [15:0] clamp16(input logic [31:0] v);
		return (v > 32'd65535) ? 16'hFFFF : v[15:0];
	endfunction

	function automatic logic [31:0] flen(input logic [31:0] start, input logic [31:0] nxt,
			input logic beyond, input logic [31:0] pos);
		logic [31:0] e;
		e = beyond ? ((nxt > 32'd0) ? nxt - 32'd1 : 32'd0) : pos;
		return (e > start) ? e - start : 32'd0;
	endfunction

	logic [31:0] cnt, fidx32, pos32;
	logic [1:0]  err, cls_n, err_n, strand_n;
	logic [31:0] sc_n, ec_n;
	logic [15:0] clen_n, noff_n, nlen_n, coff_n;
	num_t        na, nb;

	always_comb begin
		fidx32   = 32'(comm_q.fidx);
		pos32    = 32'(comm_q.pos);
		cnt      = fidx32 + 32'd1;
		if (cnt > 32'(FIELD_COUNT_MAX)) cnt = 32'(FIELD_COUNT_MAX);
		na       = fmt_q ? num[2] : num[0];
		nb       = fmt_q ? num[3] : num[1];
		if (cnt < (fmt_q ? 32'd5 : 32'd3)) err = ERR_FEW;
		else if (num_error(na.st) != ERR_NONE) err = num_error(na.st);
		else err = num_error(nb.st);
		cls_n    = CLS_EMPTY;
		err_n    = ERR_NONE;
		sc_n     = '0;
		ec_n     = '0;
		strand_n = STR_UNKNOWN;
		clen_n   = '0;
		noff_n   = '0;
		nlen_n   = '0;
		coff_n   = '0;
		if (comm_q.phase == PH_COMMENT) begin
			cls_n  = CLS_COMMENT;
			coff_n = clamp16(32'(comm_q.cpos));
		end else if (comm_q.phase == PH_DATA) begin
			if (err != ERR_NONE) begin
				cls_n = CLS_ERROR;
				err_n = err;
			end else begin
				cls_n  = CLS_OK;
				sc_n   = na.acc;
				ec_n   = nb.acc;
				clen_n = clamp16(flen(32'd0, 32'(comm_q.off1), fidx32 > 32'd0, pos32));
				if (fmt_q) begin
					if (cnt > 32'd6) strand_n = comm_q.strand6;
					noff_n = clamp16(32'(comm_q.off2));
					nlen_n = clamp16(flen(32'(comm_q.off2), 32'(comm_q.off3),
						fidx32 > 32'd2, pos32));
				end else begin
					if (cnt > 32'd5) strand_n = comm_q.strand5;
					if (cnt > 32'd3) begin
						noff_n = clamp16(32'(comm_q.off3));
						nlen_n = clamp16(flen(32'(comm_q.off3), 32'(comm_q.off4),
							fidx32 > 32'd3, pos32));
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv && is_nl) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv && is_nl) begin
			line_class     <= cls_n;
			error_kind     <= err_n;
			field_count    <= (comm_q.phase == PH_DATA) ?
				((cnt > 32'd255) ? 8'hFF : cnt[7:0]) : 8'd0;
			start_coord    <= sc_n;
			end_coord      <= ec_n;
			strand_code    <= strand_n;
			chrom_offset   <= 16'd0;
			chrom_length   <= clen_n;
			name_offset    <= noff_n;
			name_length    <= nlen_n;
			comment_offset <= coff_n;
			line_length    <= clamp16(pos32);
		end
	end

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (vld_s1 && is_nl && out_valid && !out_ready))
		else $error("input stalled without a blocked line end");

	a_class_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((line_class == CLS_ERROR) == (error_kind != ERR_NONE)))
		else $error("error kind disagrees with line class");

	a_nondata_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (line_class == CLS_EMPTY || line_class == CLS_COMMENT))
		|-> (field_count == 8'd0 && start_coord == 32'd0))
		else $error("non-data line carries data fields");
endmodule

[test/tb_genomic_interval_line_parser_core.sv]
// Testbench for genomic_interval_line_parser_core: directed and random text lines,
// every result checked field by field against a behavioral line parser model.
// Depends on glp_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_genomic_interval_line_parser_core;
	import glp_pkg::*;

	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic [1:0]  cls;
		logic [1:0]  err;
		logic [7:0]  nfields;
		logic [31:0] start_c;
		logic [31:0] end_c;
		logic [1:0]  strand;
		logic [15:0] chrom_off;
		logic [15:0] chrom_len;
		logic [15:0] name_off;
		logic [15:0] name_len;
		logic [15:0] cmt_off;
		logic [15:0] len;
	} line_rec_t;

	typedef struct {
		int          pos;
		int          fidx;
		phase_t      phase;
		int          cmt_pos;
		bit          cmt_found;
		int          foff[5];
		logic [31:0] acc[4];
		num_state_t  nst[4];
		logic [1:0]  strand_val[2];
		bit          strand_got[2];
	} scan_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic        record_format = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [7:0]  line_byte = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [1:0]  line_class;
	logic [1:0]  error_kind;
	logic [7:0]  field_count;
	logic [31:0] start_coord;
	logic [31:0] end_coord;
	logic [1:0]  strand_code;
	logic [15:0] chrom_offset;
	logic [15:0] chrom_length;
	logic [15:0] name_offset;
	logic [15:0] name_length;
	logic [15:0] comment_offset;
	logic [15:0] line_length;

	genomic_interval_line_parser_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .record_format(record_format),
		.in_valid(in_valid), .in_ready(in_ready), .line_byte(line_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.line_class(line_class), .error_kind(error_kind), .field_count(field_count),
		.start_coord(start_coord), .end_coord(end_coord), .strand_code(strand_code),
		.chrom_offset(chrom_offset), .chrom_length(chrom_length),
		.name_offset(name_offset), .name_length(name_length),
		.comment_offset(comment_offset), .line_length(line_length)
	);

	always #10 clk = ~clk;

	scan_t     live, kept;
	bit        fmt_gff;
	line_rec_t pending_lines[$];
	line_rec_t table_hint[$];
	bit        hint_valid[$];
	int        errors = 0;
	int        lines_seen = 0;
	int        bytes_sent = 0;
	int        idle_cycles = 0;
	bit        timed_out = 0;
	bit        idle_on = 1;
	bit        hold_out = 0;
	bit        hold_go = 0;

	function automatic int sat16(int v);
		return v > 65535 ? 65535 : v;
	endfunction

	function automatic void clear_scan(ref scan_t s);
		s.pos = 0; s.fidx = 0; s.phase = PH_LEAD; s.cmt_pos = 0; s.cmt_found = 0;
		for (int i = 0; i < 5; i++) s.foff[i] = 0;
		for (int i = 0; i < 4; i++) begin
			s.acc[i] = 0; s.nst[i] = NS_LEAD;
		end
		s.strand_val = '{2'd0, 2'd0};
		s.strand_got = '{0, 0};
	endfunction

	function automatic bit blank_ch(logic [7:0] b);
		return b == CH_SPACE || (b >= 8'd9 && b <= 8'd13);
	endfunction

	function automatic void digit_step(ref scan_t s, input int k, input logic [7:0] b);
		bit           dg;
		logic [63:0]  v;
		dg = b >= 8'd48 && b <= 8'd57;
		case (s.nst[k])
			NS_LEAD: begin
				if (!blank_ch(b)) begin
					if (b == CH_MINUS) s.nst[k] = NS_NEG;
					else if (b == CH_PLUS) s.nst[k] = NS_SIGN;
					else if (dg) begin
						s.nst[k] = NS_DIGIT; s.acc[k] = 32'(b - 8'd48);
					end else s.nst[k] = NS_BAD;
				end
			end
			NS_SIGN: begin
				if (dg) begin
					s.nst[k] = NS_DIGIT; s.acc[k] = 32'(b - 8'd48);
				end else s.nst[k] = NS_BAD;
			end
			NS_DIGIT: begin
				if (dg) begin
					v = 64'(s.acc[k]) * 10 + 64'(b - 8'd48);
					if (v > 64'hFFFF_FFFF) s.nst[k] = NS_BAD;
					else s.acc[k] = v[31:0];
				end else if (blank_ch(b)) s.nst[k] = NS_TRAIL;
				else s.nst[k] = NS_BAD;
			end
			NS_TRAIL: begin
				if (!blank_ch(b)) s.nst[k] = NS_BAD;
			end
			default: ;
		endcase
	endfunction

	function automatic void scan_byte(ref scan_t s, input logic [7:0] b);
		int p;
		int f;
		p = s.pos;
		if (b == CH_TAB) begin
			if (s.fidx < 255) s.fidx++;
			if (s.fidx < 5) s.foff[s.fidx] = sat16(p + 1);
		end else begin
			f = s.fidx;
			if (f >= 1 && f <= 4) digit_step(s, f - 1, b);
			if ((f == 5 || f == 6) && !s.strand_got[f - 5]) begin
				s.strand_got[f - 5] = 1;
				s.strand_val[f - 5] = b == CH_PLUS ? STR_PLUS :
					(b == CH_MINUS ? STR_MINUS : STR_UNKNOWN);
			end
		end
		if (s.phase == PH_LEAD) begin
			if (b != CH_SPACE && b != CH_TAB) begin
				if (b == CH_HASH) begin
					s.phase = PH_COMMENT; s.cmt_pos = sat16(p + 1);
				end else s.phase = PH_DATA;
			end
		end else if (s.phase == PH_COMMENT && !s.cmt_found) begin
			if (b != CH_SPACE && b != CH_TAB) begin
				s.cmt_found = 1; s.cmt_pos = p;
			end
		end
		s.pos = sat16(p + 1);
	endfunction

	function automatic logic [1:0] field_err(num_state_t st);
		if (st == NS_DIGIT || st == NS_TRAIL) return ERR_NONE;
		return st == NS_NEG ? ERR_NEGATIVE : ERR_BAD_NUM;
	endfunction

	function automatic int span_of(scan_t s, int k);
		int e;
		e = s.pos;
		if (s.fidx > k) begin
			e = s.foff[k + 1];
			e = e > 0 ? e - 1 : 0;
		end
		return e > s.foff[k] ? e - s.foff[k] : 0;
	endfunction

	function automatic line_rec_t finish_line(scan_t c, bit gff);
		line_rec_t r;
		int        cnt;
		int        a;
		r = '{default: '0};
		r.len = 16'(c.pos);
		if (c.phase == PH_COMMENT) begin
			r.cls = CLS_COMMENT; r.cmt_off = 16'(c.cmt_pos);
		end else if (c.phase == PH_DATA) begin
			cnt = c.fidx + 1;
			if (cnt > 255) cnt = 255;
			r.nfields = 8'(cnt);
			a = gff ? 2 : 0;
			if (cnt < (gff ? 5 : 3)) r.err = ERR_FEW;
			else begin
				r.err = field_err(c.nst[a]);
				if (r.err == ERR_NONE) r.err = field_err(c.nst[a + 1]);
			end
			if (r.err != ERR_NONE) r.cls = CLS_ERROR;
			else begin
				r.cls = CLS_OK;
				r.start_c = c.acc[a];
				r.end_c = c.acc[a + 1];
				if (gff) begin
					if (cnt > 6) r.strand = c.strand_val[1];
					r.name_off = 16'(c.foff[2]); r.name_len = 16'(span_of(c, 2));
				end else begin
					if (cnt > 5) r.strand = c.strand_val[0];
					if (cnt > 3) begin
						r.name_off = 16'(c.foff[3]); r.name_len = 16'(span_of(c, 3));
					end
				end
				r.chrom_off = 16'(c.foff[0]); r.chrom_len = 16'(span_of(c, 0));
			end
		end
		return r;
	endfunction

	task automatic predict_byte(logic [7:0] b, bit has_hint, line_rec_t hint);
		if (b != CH_NL) begin
			scan_byte(live, b);
			if (b >= 8'd32 && b != CH_DEL) kept = live;
		end else begin
			pending_lines = {pending_lines, finish_line(kept, fmt_gff)};
			table_hint = {table_hint, hint};
			hint_valid = {hint_valid, has_hint};
			clear_scan(live);
			clear_scan(kept);
		end
	endtask

	task automatic send_byte(logic [7:0] b, bit has_hint = 0, line_rec_t hint = '{default: '0});
		while (idle_on && $urandom_range(99) < 26) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		line_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_byte(b, has_hint, hint);
		bytes_sent++;
	endtask

	task automatic send_text(string t, bit has_hint = 0, line_rec_t hint = '{default: '0});
		for (int i = 0; i < t.len(); i++)
			send_byte(t[i], has_hint && i == t.len() - 1, hint);
	endtask

	task automatic drain_and_config(bit gff);
		in_valid <= 0;
		while (pending_lines.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1;
		record_format <= gff;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		fmt_gff = gff;
		cfg_valid <= 0;
	endtask

	function automatic string rand_num();
		string s;
		case ($urandom_range(9))
			0: s = "-5";
			1: s = "4294967295";
			2: s = "4294967296";
			3: s = "x1";
			4: s = "";
			5: s = " 12 ";
			6: s = "1 2";
			7: s = "+77";
			default: s = $sformatf("%0d", $urandom_range(100000));
		endcase
		return s;
	endfunction

	function automatic string rand_field();
		string s;
		int    n;
		s = "";
		n = $urandom_range(6);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(3))
				0: s = {s, string'(8'($urandom_range(33, 126)))};
				1: s = {s, "+"};
				2: s = {s, "-"};
				default: s = {s, string'(8'($urandom_range(97, 122)))};
			endcase
		end
		return s;
	endfunction

	task automatic random_line();
		string t;
		int    n;
		int    kind;
		kind = $urandom_range(99);
		if (kind < 70) begin
			n = $urandom_range(2, 9);
			t = (fmt_gff ? {rand_field(), "\t", rand_field(), "\t", rand_field()} : rand_field());
			t = {t, "\t", rand_num(), "\t", rand_num()};
			for (int i = 0; i < n - 3; i++) begin
				case ($urandom_range(3))
					0: t = {t, "\t+"};
					1: t = {t, "\t-"};
					2: t = {t, "\t."};
					default: t = {t, "\t", rand_field()};
				endcase
			end
			if ($urandom_range(4) == 0) t = {t, "\t\r"};
			if ($urandom_range(6) == 0) t = {" ", t};
		end else if (kind < 80) begin
			t = {$urandom_range(1) ? "  #" : "#", $urandom_range(1) ? " \t" : "", rand_field()};
		end else if (kind < 85) begin
			t = $urandom_range(1) ? " \t " : "";
		end else begin
			n = $urandom_range(12);
			t = "";
			for (int i = 0; i < n; i++) begin
				logic [7:0] c;
				c = 8'($urandom_range(255));
				if (c == CH_NL) c = 8'd0;
				t = {t, string'(c)};
			end
		end
		send_text(t);
		send_byte(CH_NL);
	endtask

	// receiver: random stalls, one long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) out_ready <= 0;
		else if (hold_out) out_ready <= 0;
		else out_ready <= idle_on ? ($urandom_range(99) >= 26) : 1'b1;
	end

	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_out <= 1;
		repeat (300) @(posedge clk);
		hold_out <= 0;
	end

	always @(posedge clk) begin
		line_rec_t e;
		if (arst_n && out_valid && out_ready) begin
			lines_seen++;
			if (pending_lines.size() == 0) begin
				errors++;
				$display("%0t: expected no result, actual class %0d", $time, line_class);
			end else begin
				e = pending_lines.pop_front();
				if (hint_valid.pop_front()) begin
					line_rec_t h;
					h = table_hint.pop_front();
					if (h.cls !== line_class || h.err !== error_kind) begin
						errors++;
						$display("%0t: table class/err expected %0d/%0d actual %0d/%0d",
							$time, h.cls, h.err, line_class, error_kind);
					end
				end else void'(table_hint.pop_front());
				if ({e.cls, e.err, e.nfields, e.start_c, e.end_c, e.strand, e.chrom_off,
					e.chrom_len, e.name_off, e.name_len, e.cmt_off, e.len} !==
					{line_class, error_kind, field_count, start_coord, end_coord,
					strand_code, chrom_offset, chrom_length, name_offset, name_length,
					comment_offset, line_length}) begin
					errors++;
					$display("%0t: mismatch expected cls=%0d err=%0d n=%0d s=%0d e=%0d str=%0d co=%0d cl=%0d no=%0d nl=%0d cm=%0d len=%0d",
						$time, e.cls, e.err, e.nfields, e.start_c, e.end_c, e.strand,
						e.chrom_off, e.chrom_len, e.name_off, e.name_len, e.cmt_off, e.len);
					$display("%0t:   actual   cls=%0d err=%0d n=%0d s=%0d e=%0d str=%0d co=%0d cl=%0d no=%0d nl=%0d cm=%0d len=%0d",
						$time, line_class, error_kind, field_count, start_coord, end_coord,
						strand_code, chrom_offset, chrom_length, name_offset, name_length,
						comment_offset, line_length);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("tb_genomic_interval_line_parser_core failed");
			$finish;
		end
	end

	typedef struct {
		string     text;
		bit        gff;
		bit        typed;
		line_rec_t hint;
	} line_case_t;

	line_case_t directed[$];

	function automatic line_rec_t cls_err(logic [1:0] c, logic [1:0] e);
		line_rec_t r;
		r = '{default: '0};
		r.cls = c; r.err = e;
		return r;
	endfunction

	initial begin
		clear_scan(live);
		clear_scan(kept);
		fmt_gff = 0;
		directed = '{
			'{"", 0, 1, cls_err(CLS_EMPTY, ERR_NONE)},
			'{" \t \t", 0, 1, cls_err(CLS_EMPTY, ERR_NONE)},
			'{"# hello", 0, 1, cls_err(CLS_COMMENT, ERR_NONE)},
			'{"  #", 0, 1, cls_err(CLS_COMMENT, ERR_NONE)},
			'{"chr1\t0\t4294967295", 0, 1, cls_err(CLS_OK, ERR_NONE)},
			'{"chr1\t10", 0, 1, cls_err(CLS_ERROR, ERR_FEW)},
			'{"chr1\t-1\t5", 0, 1, cls_err(CLS_ERROR, ERR_NEGATIVE)},
			'{"chr1\t4294967296\t5", 0, 1, cls_err(CLS_ERROR, ERR_BAD_NUM)},
			'{"chr1\t5\t+", 0, 1, cls_err(CLS_ERROR, ERR_BAD_NUM)},
			'{"chr1\t\t5", 0, 1, cls_err(CLS_ERROR, ERR_BAD_NUM)},
			'{"chr1\t+5\t 6 \tgeneA\t0\t-", 0, 0, '{default: '0}},
			'{"chr1\t5\t6\tn\t0\t", 0, 0, '{default: '0}},
			'{"chr1\t1 2\t6", 0, 0, '{default: '0}},
			'{"chr1\t5\t6\t\r\t", 0, 0, '{default: '0}},
			'{"chrX\tsrc\tgene\t100\t200\t.\t+", 1, 0, '{default: '0}},
			'{"chrX\tsrc\tgene\t100", 1, 1, cls_err(CLS_ERROR, ERR_FEW)},
			'{"chrX\tsrc\tgene\t-3\t200", 1, 1, cls_err(CLS_ERROR, ERR_NEGATIVE)},
			'{"c\ts\tg\t1\t2\t.\t", 1, 0, '{default: '0}},
			'{"#\t \x01", 1, 0, '{default: '0}},
			'{"\x7f\x00\xff\x80", 1, 0, '{default: '0}}
		};
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (directed[i]) begin
			if (directed[i].gff != fmt_gff) drain_and_config(directed[i].gff);
			send_text(directed[i].text);
			send_byte(CH_NL, directed[i].typed, directed[i].hint);
		end
		drain_and_config(0);
		// saturate the field count
		for (int i = 0; i < 300; i++) send_byte(CH_TAB);
		send_text("x");
		send_byte(CH_NL);
		// back-pressure: hold the receiver while lines keep coming
		hold_go = 1;
		for (int i = 0; i < 6; i++) begin
			send_text("c\t1\t2");
			send_byte(CH_NL);
		end
		for (int ph = 0; ph < 4; ph++) begin
			drain_and_config(ph % 2);
			idle_on = ph != 2;
			while (bytes_sent < 600 + (ph + 1) * 350) random_line();
		end
		idle_on = 1;
		in_valid <= 0;
		while (pending_lines.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("Covered %0d bytes and %0d lines in BED and GFF layouts,", bytes_sent, lines_seen);
		$display("including field-count saturation, number errors, comments and receiver hold-off.");
		if (errors == 0) $display("tb_genomic_interval_line_parser_core passed");
		else $display("tb_genomic_interval_line_parser_core failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/glp_pkg.sv
rtl/glp_num_lane.sv
rtl/genomic_interval_line_parser_core.sv
test/tb_genomic_interval_line_parser_core.sv
